// ===== src/nhp_pkg.sv =====
package nhp_pkg;

    // Width of the history depth register and of the rank field
    localparam int DEPTH_W     = 4;
    localparam int RANK_W      = 3;
    localparam int DEPTH_RESET = 4;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_RANK
    } state_t;

endpackage

// ===== src/nearest_history_predictor.sv =====
// Channel   | Direction | Handshake                 | Beat contents
// ----------+-----------+---------------------------+----------------------------------------
// input     | in        | in_valid / in_ready       | coord_value, frame_end
// result    | out       | out_valid / out_ready     | predicted, rank, residual, raw_value,
//           |           |                           | frame_last
// config    | in        | cfg_we (no wait)          | cfg_wdata -> history_depth
//
// One input beat at a time. A warm-up beat goes from acceptance to S_RANK and back to idle;
// a predicted beat first passes through S_SCAN, where K is the effective history depth and the
// slot scan runs over K slots, one history value per cycle, through a single distance
// comparator. The history row is read from the memory in the acceptance cycle.
// Reset clears the control state; the history memory is not cleared.
// A stalled result waits in the output register and the next input beat is still accepted;
// only a second finished result waits until the first has gone.
module nearest_history_predictor #(
    parameter int MAX_HISTORY = 8,
    parameter int MAX_COORDS  = 4096,
    parameter int COORD_BITS  = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration
    input  logic                              cfg_we,
    input  logic [nhp_pkg::DEPTH_W-1:0]       cfg_wdata,
    // input channel
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [COORD_BITS-1:0]             coord_value,
    input  logic                              frame_end,
    // result channel
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              predicted,
    output logic [nhp_pkg::RANK_W-1:0]        rank,
    output logic signed [COORD_BITS:0]        residual,
    output logic [COORD_BITS-1:0]             raw_value,
    output logic                              frame_last
);
    import nhp_pkg::*;

    localparam int SLOT_W = (MAX_HISTORY > 1) ? $clog2(MAX_HISTORY) : 1;
    localparam int POS_W  = (MAX_COORDS > 1) ? $clog2(MAX_COORDS) : 1;
    localparam int CNT_W  = $clog2(MAX_HISTORY + 1);
    // effective depth can never exceed what the depth register can hold
    localparam int K_CAP  = (MAX_HISTORY < (2 ** DEPTH_W) - 1) ? MAX_HISTORY
                                                                 : (2 ** DEPTH_W) - 1;

    typedef logic [MAX_HISTORY-1:0][COORD_BITS-1:0] row_t;

    // History memory: one row per frame position, one slot per earlier frame
    row_t hist_mem [MAX_COORDS];

    state_t                 state_reg, state_next;
    logic [DEPTH_W-1:0]     depth_reg;
    logic [DEPTH_W-1:0]     frames_held_reg;
    logic [SLOT_W-1:0]      oldest_slot_reg;
    logic [POS_W-1:0]       position_reg;

    logic [COORD_BITS-1:0]  cur_reg;
    logic                   last_reg;
    row_t                   rd_data_reg;

    logic [SLOT_W-1:0]      scan_idx_reg;
    logic [COORD_BITS-1:0]  best_val_reg;
    logic [COORD_BITS-1:0]  best_dist_reg;

    logic                   out_valid_reg;
    logic                   predicted_reg;
    logic [RANK_W-1:0]      rank_reg;
    logic signed [COORD_BITS:0] residual_reg;
    logic [COORD_BITS-1:0]  raw_value_reg;
    logic                   frame_last_reg;

    logic [DEPTH_W-1:0]     k_eff;
    logic                   pred_mode;
    logic                   accept;
    logic                   finish;
    logic                   scan_last;
    logic                   out_free;

    logic [COORD_BITS-1:0]  scan_val;
    logic [COORD_BITS-1:0]  scan_dist;
    logic                   scan_take;

    logic [CNT_W-1:0]       below_cnt;
    logic signed [COORD_BITS:0] resid_val;
    logic [SLOT_W-1:0]      wr_slot;

    // Effective depth: zero acts as one, clamp at the slot count or at K_CAP, whichever is smaller
    always_comb
    begin
        if (depth_reg == '0)
            k_eff = DEPTH_W'(1);
        else if (int'(depth_reg) > K_CAP)
            k_eff = DEPTH_W'(K_CAP);
        else
            k_eff = depth_reg;
    end

    assign pred_mode = (frames_held_reg >= k_eff);
    assign accept    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign scan_last = (int'(scan_idx_reg) == int'(k_eff) - 1);

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state and handshake
    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        finish     = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                    state_next = pred_mode ? S_SCAN : S_RANK;
            end
            S_SCAN:
            begin
                if (scan_last)
                    state_next = S_RANK;
            end
            S_RANK:
            begin
                // hold until the output register can take the beat
                if (out_free)
                begin
                    finish     = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Memory: read the row on acceptance, write one slot when the item retires
    assign wr_slot = pred_mode ? oldest_slot_reg : SLOT_W'(frames_held_reg);

    always_ff @(posedge clk)
    begin
        if (accept)
            rd_data_reg <= hist_mem[position_reg];
        if (finish)
            hist_mem[position_reg][wr_slot] <= cur_reg;
    end

    // Scan step: distance of one history value against the current value
    always_comb
    begin
        scan_val  = rd_data_reg[scan_idx_reg];
        scan_dist = (scan_val > cur_reg) ? (scan_val - cur_reg) : (cur_reg - scan_val);
        scan_take = (scan_idx_reg == '0) || (scan_dist < best_dist_reg) ||
                    ((scan_dist == best_dist_reg) && (scan_val < best_val_reg));
    end

    // Rank: count of held values strictly below the nearest one
    always_comb
    begin
        below_cnt = '0;
        for (int s = 0; s < MAX_HISTORY; s++)
        begin
            if ((s < int'(k_eff)) && (rd_data_reg[s] < best_val_reg))
                below_cnt = below_cnt + CNT_W'(1);
        end
        resid_val = $signed({1'b0, best_val_reg}) - $signed({1'b0, cur_reg});
    end

    // Item capture and scan registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cur_reg      <= coord_value;
            last_reg     <= frame_end;
            scan_idx_reg <= '0;
        end
        else if (state_reg == S_SCAN)
        begin
            scan_idx_reg <= scan_idx_reg + SLOT_W'(1);
            if (scan_take)
            begin
                best_val_reg  <= scan_val;
                best_dist_reg <= scan_dist;
            end
        end
    end

    // Frame bookkeeping and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg       <= DEPTH_W'(DEPTH_RESET);
            frames_held_reg <= '0;
            oldest_slot_reg <= '0;
            position_reg    <= '0;
        end
        else if (cfg_we)
        begin
            // restart warm-up
            depth_reg       <= cfg_wdata;
            frames_held_reg <= '0;
            oldest_slot_reg <= '0;
            position_reg    <= '0;
        end
        else if (finish)
        begin
            if (last_reg)
                position_reg <= '0;
            else if (position_reg == POS_W'(MAX_COORDS - 1))
                position_reg <= '0;
            else
                position_reg <= position_reg + POS_W'(1);

            if (last_reg)
            begin
                if (pred_mode)
                begin
                    if (int'(oldest_slot_reg) + 1 >= int'(k_eff))
                        oldest_slot_reg <= '0;
                    else
                        oldest_slot_reg <= oldest_slot_reg + SLOT_W'(1);
                end
                else
                begin
                    frames_held_reg <= frames_held_reg + DEPTH_W'(1);
                    oldest_slot_reg <= '0;
                end
            end
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (finish)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            predicted_reg  <= pred_mode;
            rank_reg       <= pred_mode ? RANK_W'(below_cnt) : '0;
            residual_reg   <= pred_mode ? resid_val : '0;
            raw_value_reg  <= cur_reg;
            frame_last_reg <= last_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign predicted  = predicted_reg;
    assign rank       = rank_reg;
    assign residual   = residual_reg;
    assign raw_value  = raw_value_reg;
    assign frame_last = frame_last_reg;

`ifndef NO_ASSERTIONS
    a_oldest_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        pred_mode |-> (int'(oldest_slot_reg) < int'(k_eff)))
        else $error("oldest slot beyond effective depth");

    a_frames_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (frames_held_reg <= k_eff))
        else $error("frames held above effective depth");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (int'(scan_idx_reg) < int'(k_eff)))
        else $error("scan index beyond effective depth");

    a_finish_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
        finish |=> out_valid)
        else $error("retired item not presented");

    a_warmup_skips_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !pred_mode) |=> (state_reg == S_RANK))
        else $error("warm-up item entered the scan");
`endif

endmodule
